// ----- rtl/core/rmpchk_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rmpchk_pkg
// Shared types, codes and constants of the multichannel ramp checker.
// ----------------------------------------------------------------------------
package rmpchk_pkg;

  localparam int CHANNELS    = 16;
  localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_W       = 29;
  localparam int SIZE_W      = 32;
  localparam int WORD_W      = 64;
  localparam int ID_W        = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [ID_W-1:0] UNLOCKED_ID = 8'hff;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_WORD  = 2'd1,
    CMD_CLEAR = 2'd2
  } command_t;

  typedef enum logic [2:0] {
    STATUS_OK          = 3'd0,
    STATUS_SIZE        = 3'd1,
    STATUS_HEADER      = 3'd2,
    STATUS_ID_RANGE    = 3'd3,
    STATUS_ID_MISMATCH = 3'd4,
    STATUS_CH_RANGE    = 3'd5,
    STATUS_RAMP        = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    KIND_START_ERR   = 3'd0,
    KIND_START_EMPTY = 3'd1,
    KIND_START_PKT   = 3'd2,
    KIND_CLEAR       = 3'd3,
    KIND_WORD        = 3'd4
  } kind_t;

  // Register index, taken from address bit 2.
  typedef enum logic {
    REG_HEADER = 1'b0,
    REG_LIMIT  = 1'b1
  } reg_index_t;

  typedef struct packed {
    kind_t              kind;
    logic [POS_W-1:0]   pos;
    logic               last;
    logic [WORD_W-1:0]  word;
  } entry_t;

  // The low 40 bits count and wrap; the upper 24 bits are kept.
  function automatic logic [WORD_W-1:0] step_counter(input logic [WORD_W-1:0] ctr);
    step_counter = {ctr[63:40], ctr[39:0] + 40'd1};
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/rmpchk_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rmpchk_front
// Accepts transactions, tracks packet length and word position, and queues
// one classified entry for each transaction that needs the back end.
// ----------------------------------------------------------------------------
module rmpchk_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           item_valid,
  output logic                                item_ready,
  input  wire logic [1:0]                     command,
  input  wire logic [rmpchk_pkg::SIZE_W-1:0]  byte_size,
  input  wire logic [rmpchk_pkg::WORD_W-1:0]  data_word,
  input  wire logic                           q_full,
  output logic                                q_push,
  output rmpchk_pkg::entry_t                  q_entry
);
  import rmpchk_pkg::*;

  logic [POS_W-1:0] words_left;
  logic [POS_W-1:0] words_left_next;
  logic [POS_W-1:0] word_position;
  logic [POS_W-1:0] word_position_next;
  logic             accept;

  assign item_ready = !q_full;
  assign accept     = item_valid && !q_full;

  always_comb begin
    words_left_next    = words_left;
    word_position_next = word_position;
    q_push             = 1'b0;
    q_entry.kind       = KIND_CLEAR;
    q_entry.pos        = word_position;
    q_entry.last       = (words_left == POS_W'(1));
    q_entry.word       = data_word;
    case (command_t'(command))
      CMD_START: begin
        q_push             = accept;
        words_left_next    = '0;
        word_position_next = '0;
        q_entry.pos        = '0;
        if (byte_size[2:0] != 3'd0) begin
          q_entry.kind = KIND_START_ERR;
        end else if (byte_size[SIZE_W-1:3] == '0) begin
          q_entry.kind = KIND_START_EMPTY;
        end else begin
          q_entry.kind    = KIND_START_PKT;
          words_left_next = byte_size[SIZE_W-1:3];
        end
      end
      CMD_WORD: begin
        // A word outside any packet is consumed without effect.
        if (words_left != '0) begin
          q_push             = accept;
          q_entry.kind       = KIND_WORD;
          words_left_next    = words_left - POS_W'(1);
          word_position_next = word_position + POS_W'(1);
        end
      end
      CMD_CLEAR: begin
        q_push       = accept;
        q_entry.kind = KIND_CLEAR;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      words_left    <= '0;
      word_position <= '0;
    end else if (accept) begin
      words_left    <= words_left_next;
      word_position <= word_position_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/rmpchk_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rmpchk_queue
// Short first-in first-out queue of classified entries between front and back.
// ----------------------------------------------------------------------------
module rmpchk_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  rmpchk_pkg::entry_t      push_entry,
  output logic                    full,
  input  wire logic               pop,
  output logic                    empty,
  output rmpchk_pkg::entry_t      head
);
  import rmpchk_pkg::*;

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/rmpchk_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rmpchk_back
// Checks one queued entry per cycle, while the result register is free or being
// taken, against the header, the source id and the per-channel counters, and holds the verdict in the output register.
// ----------------------------------------------------------------------------
module rmpchk_back (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [rmpchk_pkg::ID_W-1:0]    header_value,
  input  wire logic [rmpchk_pkg::ID_W-1:0]    source_id_limit,
  input  wire logic                           q_empty,
  input  rmpchk_pkg::entry_t                  head,
  output logic                                q_pop,
  output logic                                result_valid,
  input  wire logic                           result_ready,
  output logic [2:0]                          status,
  output logic [rmpchk_pkg::POS_W-1:0]        word_index,
  output logic [rmpchk_pkg::WORD_W-1:0]       expected_word,
  output logic [rmpchk_pkg::WORD_W-1:0]       seen_word
);
  import rmpchk_pkg::*;

  logic [WORD_W-1:0] counter [CHANNELS];
  logic              dropping;
  logic              dropping_next;
  logic [ID_W-1:0]   locked_source;
  logic [ID_W-1:0]   locked_source_next;

  logic              fire;
  logic [WORD_W-1:0] w;
  logic [7:0]        ch;
  logic [CH_W-1:0]   idx;
  logic              ch_ok;
  logic              first;
  logic [ID_W-1:0]   id;
  logic [WORD_W-1:0] exp_val;
  logic              emit;
  status_t           st;
  logic [WORD_W-1:0] exp_out;
  logic [WORD_W-1:0] seen_out;
  logic [POS_W-1:0]  idx_out;
  logic              seed;
  logic              upd;

  assign fire  = !q_empty && (!result_valid || result_ready);
  assign q_pop = fire;

  assign w     = head.word;
  assign ch    = w[47:40];
  assign idx   = ch[CH_W-1:0];
  assign ch_ok = ({1'b0, ch} < 9'(CHANNELS));
  assign first = (head.pos == '0);
  assign id    = w[55:48];
  // On the first word the counter of its channel is the freshly seeded value.
  assign exp_val = first ? {w[63:48], ch, 40'd0} : counter[idx];

  always_comb begin
    emit               = 1'b0;
    st                 = STATUS_OK;
    exp_out            = '0;
    seen_out           = '0;
    idx_out            = '0;
    seed               = 1'b0;
    upd                = 1'b0;
    dropping_next      = dropping;
    locked_source_next = locked_source;
    case (head.kind)
      KIND_START_ERR: begin
        dropping_next = 1'b0;
        emit          = 1'b1;
        st            = STATUS_SIZE;
      end
      KIND_START_EMPTY: begin
        dropping_next = 1'b0;
        emit          = 1'b1;
      end
      KIND_START_PKT: begin
        dropping_next = 1'b0;
      end
      KIND_CLEAR: begin
        locked_source_next = UNLOCKED_ID;
      end
      KIND_WORD: begin
        if (dropping) begin
          if (head.last) begin
            dropping_next = 1'b0;
          end
        end else begin
          dropping_next = !head.last;
          idx_out       = head.pos;
          seen_out      = w;
          if (first && (w[63:56] != header_value)) begin
            emit = 1'b1;
            st   = STATUS_HEADER;
          end else if (first && (id >= source_id_limit)) begin
            emit = 1'b1;
            st   = STATUS_ID_RANGE;
          end else if (first && (locked_source != UNLOCKED_ID) && (locked_source != id)) begin
            emit = 1'b1;
            st   = STATUS_ID_MISMATCH;
          end else begin
            // The id locks and the counters seed even if the channel then fails.
            if (first) begin
              seed = 1'b1;
              if (locked_source == UNLOCKED_ID) begin
                locked_source_next = id;
              end
            end
            if (!ch_ok) begin
              emit = 1'b1;
              st   = STATUS_CH_RANGE;
            end else if (w != exp_val) begin
              emit    = 1'b1;
              st      = STATUS_RAMP;
              exp_out = exp_val;
            end else begin
              upd           = 1'b1;
              dropping_next = 1'b0;
              emit          = head.last;
            end
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CHANNELS; i++) begin
      if (fire && upd && (idx == CH_W'(i))) begin
        counter[i] <= step_counter(exp_val);
      end else if (fire && seed) begin
        counter[i] <= {w[63:48], 8'(i), 40'd0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dropping      <= 1'b0;
      locked_source <= UNLOCKED_ID;
      result_valid  <= 1'b0;
    end else begin
      if (fire) begin
        dropping      <= dropping_next;
        locked_source <= locked_source_next;
      end
      if (fire && emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      status        <= st;
      word_index    <= idx_out;
      expected_word <= exp_out;
      seen_word     <= seen_out;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/multichannel_ramp_checker.sv -----
`default_nettype none
// A transaction that causes a result is written into the queue, then checked by the back end into the result register.
// Throughput: one transaction per cycle while the result side takes results, set by the check and counter update
// in the back end; a four-entry queue absorbs back-pressure from the result side.
// Reset: synchronous and active high; it resets the control and configuration registers, unlocks the source id and
// empties the queue. The channel counters are not reset; the first word of a packet seeds them.
// ----------------------------------------------------------------------------
// multichannel_ramp_checker
// Packet checker for per-channel 64-bit counter ramps with an APB register port.
// ----------------------------------------------------------------------------
module multichannel_ramp_checker (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [rmpchk_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [rmpchk_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [rmpchk_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                    pready,
  input  wire logic                               item_valid,
  output logic                                    item_ready,
  input  wire logic [1:0]                         command,
  input  wire logic [rmpchk_pkg::SIZE_W-1:0]      byte_size,
  input  wire logic [rmpchk_pkg::WORD_W-1:0]      data_word,
  output logic                                    result_valid,
  input  wire logic                               result_ready,
  output logic [2:0]                              status,
  output logic [rmpchk_pkg::POS_W-1:0]            word_index,
  output logic [rmpchk_pkg::WORD_W-1:0]           expected_word,
  output logic [rmpchk_pkg::WORD_W-1:0]           seen_word
);
  import rmpchk_pkg::*;

  logic [ID_W-1:0] header_value;
  logic [ID_W-1:0] source_id_limit;
  reg_index_t      reg_sel;
  logic            cfg_write;

  logic            q_push;
  entry_t          q_entry;
  logic            q_full;
  logic            q_pop;
  logic            q_empty;
  entry_t          q_head;

  assign pready    = 1'b1;
  assign reg_sel   = reg_index_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_value    <= 8'd0;
      source_id_limit <= 8'd255;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_HEADER: header_value    <= pwdata[ID_W-1:0];
        REG_LIMIT:  source_id_limit <= pwdata[ID_W-1:0];
        default:    header_value    <= header_value;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_HEADER: prdata = {(CFG_DATA_W-ID_W)'(0), header_value};
      REG_LIMIT:  prdata = {(CFG_DATA_W-ID_W)'(0), source_id_limit};
      default:    prdata = '0;
    endcase
  end

  rmpchk_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .command    (command),
    .byte_size  (byte_size),
    .data_word  (data_word),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_entry)
  );

  rmpchk_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  rmpchk_back u_back (
    .clk             (clk),
    .rst             (rst),
    .header_value    (header_value),
    .source_id_limit (source_id_limit),
    .q_empty         (q_empty),
    .head            (q_head),
    .q_pop           (q_pop),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .status          (status),
    .word_index      (word_index),
    .expected_word   (expected_word),
    .seen_word       (seen_word)
  );

endmodule
`default_nettype wire

// ----- rtl/core/rmpchk_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rmpchk_checker
// Port-level checks of the ramp checker's result channel, bound to the top.
// ----------------------------------------------------------------------------
module rmpchk_checker (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               result_valid,
  input  wire logic                               result_ready,
  input  wire logic [2:0]                         status,
  input  wire logic [rmpchk_pkg::POS_W-1:0]       word_index,
  input  wire logic [rmpchk_pkg::WORD_W-1:0]      expected_word,
  input  wire logic [rmpchk_pkg::WORD_W-1:0]      seen_word
);
  import rmpchk_pkg::*;

  // A stalled result keeps its payload until the transaction completes.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(status)
      && $stable(word_index) && $stable(expected_word) && $stable(seen_word))
    else $error("result changed while stalled");

  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // Only a ramp mismatch carries an expected counter value.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (status != STATUS_RAMP) |-> expected_word == '0)
    else $error("expected word set without a ramp mismatch");

  // A size verdict on a packet start refers to no word.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == STATUS_SIZE) |-> (word_index == '0) && (seen_word == '0))
    else $error("size verdict carries word data");

  // Header and id verdicts are only ever given on the first word.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && ((status == STATUS_HEADER) || (status == STATUS_ID_RANGE)
      || (status == STATUS_ID_MISMATCH)) |-> word_index == '0)
    else $error("first-word verdict on a later word");

endmodule

bind multichannel_ramp_checker rmpchk_checker u_rmpchk_checker (.*);
`default_nettype wire

// ----- dv/multichannel_ramp_checker_tb.sv -----
// ----------------------------------------------------------------------------
// multichannel_ramp_checker_tb
// Self-checking bench for the ramp checker. Packets of counter ramps, with and
// without faults, are pushed through the item port under random idle and
// stall bursts. A behavioural copy of the checker predicts every verdict, and
// each result transaction is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module multichannel_ramp_checker_tb;
  import rmpchk_pkg::*;

  localparam logic [1:0] CMD_RESERVED   = 2'd3;
  localparam int         HOLD_CYCLES    = 300;
  localparam int         WATCHDOG_LIMIT = 5000;
  localparam int         SETTLE_CYCLES  = 10;

  typedef enum {FAULT_NONE, FAULT_CH_RANGE, FAULT_RAMP, FAULT_TRUNCATE} ramp_fault_t;

  typedef struct packed {
    status_t           st;
    logic [POS_W-1:0]  idx;
    logic [WORD_W-1:0] exp;
    logic [WORD_W-1:0] seen;
  } verdict_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  item_valid;
  logic                  item_ready;
  logic [1:0]            command;
  logic [SIZE_W-1:0]     byte_size;
  logic [WORD_W-1:0]     data_word;
  logic                  result_valid;
  logic                  result_ready;
  logic [2:0]            status;
  logic [POS_W-1:0]      word_index;
  logic [WORD_W-1:0]     expected_word;
  logic [WORD_W-1:0]     seen_word;

  multichannel_ramp_checker u_top (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .command       (command),
    .byte_size     (byte_size),
    .data_word     (data_word),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .status        (status),
    .word_index    (word_index),
    .expected_word (expected_word),
    .seen_word     (seen_word)
  );

  // Predicted checker state.
  logic [7:0]        hdr_cfg      = 8'h00;
  logic [7:0]        limit_cfg    = 8'hff;
  logic [ID_W-1:0]   locked_id    = UNLOCKED_ID;
  logic [WORD_W-1:0] ramp_ctr [CHANNELS];
  logic [POS_W-1:0]  pkt_left     = '0;
  logic [POS_W-1:0]  pkt_pos      = '0;
  logic              pkt_dropping = 1'b0;

  verdict_t    verdict_q [$];
  int unsigned items_sent   = 0;
  int          err_count    = 0;
  int          quiet_cycles = 0;
  bit          src_idle_en  = 1'b1;
  bit          sink_idle_en = 1'b1;
  bit          hold_results = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Returns 1 when the transaction produces a verdict, which is then in v.
  function automatic bit predict_verdict(input logic [1:0] cmd, input logic [31:0] size,
                                         input logic [63:0] w, output verdict_t v);
    logic [POS_W-1:0] pos;
    logic [7:0]       id;
    logic [7:0]       ch;
    v = '0;
    if (cmd == CMD_START) begin
      pkt_left     = '0;
      pkt_pos      = '0;
      pkt_dropping = 1'b0;
      if (size[2:0] != 3'd0) begin
        v.st = STATUS_SIZE;
        return 1'b1;
      end
      if (size < 32'd8) return 1'b1;
      pkt_left = size[31:3];
      return 1'b0;
    end
    if (cmd == CMD_CLEAR) begin
      locked_id = UNLOCKED_ID;
      return 1'b0;
    end
    if (cmd != CMD_WORD || pkt_left == '0) return 1'b0;

    pos      = pkt_pos;
    pkt_left = pkt_left - 1'b1;
    pkt_pos  = pkt_pos + 1'b1;
    if (pkt_dropping) begin
      if (pkt_left == '0) pkt_dropping = 1'b0;
      return 1'b0;
    end
    // Any error from here on drops the rest of the packet.
    pkt_dropping = (pkt_left != '0);
    v.idx  = pos;
    v.seen = w;

    if (pos == '0) begin
      id = w[55:48];
      if (w[63:56] != hdr_cfg) begin
        v.st = STATUS_HEADER;
        return 1'b1;
      end
      if (id >= limit_cfg) begin
        v.st = STATUS_ID_RANGE;
        return 1'b1;
      end
      if (locked_id == UNLOCKED_ID) begin
        locked_id = id;
      end else if (locked_id != id) begin
        v.st = STATUS_ID_MISMATCH;
        return 1'b1;
      end
      foreach (ramp_ctr[i]) ramp_ctr[i] = {w[63:48], 48'h0} + (64'(i) << 40);
    end

    ch = w[47:40];
    if (ch >= CHANNELS) begin
      v.st = STATUS_CH_RANGE;
      return 1'b1;
    end
    if (w != ramp_ctr[ch]) begin
      v.st  = STATUS_RAMP;
      v.exp = ramp_ctr[ch];
      return 1'b1;
    end
    if (ramp_ctr[ch][39:0] == '1) ramp_ctr[ch][39:0] = '0;
    else ramp_ctr[ch] = ramp_ctr[ch] + 64'd1;

    pkt_dropping = 1'b0;
    return (pkt_left == '0);
  endfunction

  function automatic logic [7:0] pick_source();
    if (locked_id != UNLOCKED_ID) return locked_id;
    if (limit_cfg == 8'd0) return 8'd0;
    return 8'($urandom_range(0, limit_cfg - 1));
  endfunction

  // Offers one transaction and returns at the edge where it is accepted.
  task automatic send_item(input logic [1:0] cmd, input logic [31:0] size,
                           input logic [63:0] w);
    verdict_t v;
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    item_valid <= 1'b1;
    command    <= cmd;
    byte_size  <= size;
    data_word  <= w;
    do @(posedge clk); while (!item_ready);
    if (predict_verdict(cmd, size, w, v)) verdict_q.push_back(v);
    if (cmd != CMD_RESERVED) items_sent++;
  endtask

  task automatic send_ramp_packet(input int unsigned nwords, input logic [7:0] hdr,
                                  input logic [7:0] src, input ramp_fault_t fault);
    logic [63:0] lane [CHANNELS];
    logic [63:0] w;
    int unsigned fault_at;
    int unsigned n_send;
    int unsigned ch;
    fault_at = $urandom_range(0, nwords - 1);
    n_send   = (fault == FAULT_TRUNCATE) ? fault_at : nwords;
    for (int i = 0; i < CHANNELS; i++) lane[i] = {hdr, src, 8'(i), 40'h0};
    send_item(CMD_START, 32'(nwords * 8), {$urandom, $urandom});
    for (int k = 0; k < n_send; k++) begin
      ch       = $urandom_range(0, CHANNELS - 1);
      w        = lane[ch];
      lane[ch] = {w[63:40], w[39:0] + 40'd1};
      if (k == fault_at && fault == FAULT_CH_RANGE)
        w[47:40] = 8'($urandom_range(CHANNELS, 255));
      else if (k == fault_at && fault == FAULT_RAMP)
        w = w ^ (64'd1 << $urandom_range(0, 63));
      // Stray commands inside a packet must not disturb it.
      if ($urandom_range(0, 39) == 0)
        send_item($urandom_range(0, 1) ? CMD_CLEAR : CMD_RESERVED, $urandom,
                  {$urandom, $urandom});
      send_item(CMD_WORD, $urandom, w);
    end
  endtask

  // Waits until every predicted verdict has been seen, then lets the pipeline settle.
  task automatic wait_idle();
    item_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Two APB writes back to back: header register, then source id limit.
  task automatic write_registers(input logic [7:0] hdr, input logic [7:0] lim);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_HEADER, 2'b00};
    pwdata  <= {24'($urandom), hdr};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    hdr_cfg = hdr;
    penable <= 1'b0;
    paddr   <= {REG_LIMIT, 2'b00};
    pwdata  <= {24'($urandom), lim};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    limit_cfg = lim;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic test_directed_cases();
    send_item(CMD_START, 32'd0, '1);
    send_item(CMD_START, 32'd7, '0);
    send_item(CMD_START, 32'hffff_ffff, '1);
    send_item(CMD_WORD, '1, '1);
    send_item(CMD_RESERVED, '1, '1);
    send_ramp_packet(1, 8'h00, 8'h05, FAULT_NONE);
    send_ramp_packet(2, 8'ha5, 8'h05, FAULT_NONE);
    send_ramp_packet(2, 8'h00, 8'hff, FAULT_NONE);
    send_ramp_packet(2, 8'h00, 8'h06, FAULT_NONE);
    send_item(CMD_CLEAR, '0, '0);
    send_ramp_packet(3, 8'h00, 8'h06, FAULT_CH_RANGE);
    send_ramp_packet(3, 8'h00, 8'h06, FAULT_RAMP);
    // The largest packet is opened, cleared mid-way and then abandoned.
    send_item(CMD_START, 32'hffff_fff8, '0);
    send_item(CMD_WORD, '0, {8'h00, pick_source(), 8'h00, 40'h0});
    send_item(CMD_CLEAR, '0, '0);
    send_item(CMD_START, 32'd8, '1);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    logic [7:0] hdr_set [4] = '{8'hff, 8'hff, 8'h00, 8'h5a};
    logic [7:0] lim_set [4] = '{8'h00, 8'h01, 8'hff, 8'h80};
    for (int s = 0; s < 4; s++) begin
      write_registers(hdr_set[s], lim_set[s]);
      send_item(CMD_CLEAR, $urandom, {$urandom, $urandom});
      send_ramp_packet(3, hdr_cfg, pick_source(), FAULT_NONE);
      send_ramp_packet(2, hdr_cfg, 8'hfe, FAULT_NONE);
      wait_idle();
    end
  endtask

  // The result side holds off while every transaction produces a verdict,
  // so the internal queue fills and the item port has to stall.
  task automatic test_result_backpressure();
    src_idle_en  = 1'b0;
    hold_results = 1'b1;
    for (int k = 0; k < 24; k++)
      send_item(CMD_START, 32'($urandom_range(0, 7)), {$urandom, $urandom});
    src_idle_en = 1'b1;
    wait_idle();
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned goal;
    int unsigned nwords;
    logic [7:0]  src;
    goal = items_sent + n_items;
    while (items_sent < goal) begin
      nwords = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
      src    = pick_source();
      case ($urandom_range(0, 19))
        0: send_item(CMD_START, $urandom, {$urandom, $urandom});
        1: send_item(CMD_CLEAR, $urandom, {$urandom, $urandom});
        2: send_item(CMD_RESERVED, $urandom, {$urandom, $urandom});
        3: send_item(CMD_WORD, $urandom, {$urandom, $urandom});
        4: send_item(CMD_START, 32'($urandom_range(0, 15)), {$urandom, $urandom});
        5: send_ramp_packet(nwords, hdr_cfg ^ 8'($urandom_range(1, 255)), src, FAULT_NONE);
        6: send_ramp_packet(nwords, hdr_cfg, 8'($urandom), FAULT_NONE);
        7: send_ramp_packet(nwords, hdr_cfg, src, FAULT_CH_RANGE);
        8, 9: send_ramp_packet(nwords, hdr_cfg, src, FAULT_RAMP);
        10: send_ramp_packet(nwords, hdr_cfg, src, FAULT_TRUNCATE);
        default: send_ramp_packet(nwords, hdr_cfg, src, FAULT_NONE);
      endcase
    end
    wait_idle();
  endtask

  initial begin
    rst          <= 1'b1;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    item_valid   <= 1'b0;
    command      <= CMD_START;
    byte_size    <= '0;
    data_word    <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_register_extremes();
    test_result_backpressure();
    for (int phase = 0; phase < 4; phase++) begin
      if (phase == 3) begin
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
      end
      write_registers(8'($urandom), 8'($urandom_range(16, 255)));
      send_item(CMD_CLEAR, $urandom, {$urandom, $urandom});
      test_random_traffic(250);
    end

    wait_idle();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Result side: random stall bursts, plus one long hold on request.
  initial begin
    result_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
        result_ready <= 1'b1;
      end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        result_ready <= 1'b1;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  function automatic void check_field(input string label, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, label, want, got);
    end
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && result_valid && result_ready) begin
      if (verdict_q.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result: expected none, actual status %0d", $time, status);
      end else begin
        want = verdict_q.pop_front();
        check_field("status", 64'(want.st), 64'(status));
        check_field("word_index", 64'(want.idx), 64'(word_index));
        check_field("expected_word", want.exp, expected_word);
        check_field("seen_word", want.seen, seen_word);
      end
    end
  end

  // Ends the run if neither port moves a transaction for too long.
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
